>>> src/lidar_scan_sector_and_outlier_filter_defines.svh
// Assertion macros used by the lidar scan filter top level.
`ifndef LIDAR_SCAN_SECTOR_AND_OUTLIER_FILTER_DEFINES_SVH
`define LIDAR_SCAN_SECTOR_AND_OUTLIER_FILTER_DEFINES_SVH

`ifndef SYNTHESIS
`define LSSOF_ASSERT_IMPLIES(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("lssof: assertion failed");
`define LSSOF_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("lssof: assertion failed");
`else
`define LSSOF_ASSERT_IMPLIES(name, clk, rstn, ante, cons)
`define LSSOF_ASSERT_NEXT(name, clk, rstn, ante, cons)
`endif

`endif

>>> src/lssof_pkg.sv
package lssof_pkg;

  localparam int unsigned RANGE_BITS = 16;
  localparam int unsigned ANGLE_BITS = 16;
  localparam int unsigned INTENSITY_BITS = 16;
  localparam int unsigned CMD_DEPTH = 4;

  typedef enum logic [2:0] {
    REG_ISOLATION_LIMIT    = 3'd0,
    REG_SECTOR_MASK_ENABLE = 3'd1,
    REG_SECTOR_LOW_ANGLE   = 3'd2,
    REG_SECTOR_HIGH_ANGLE  = 3'd3,
    REG_VALID_RANGE_LOW    = 3'd4,
    REG_VALID_RANGE_HIGH   = 3'd5,
    REG_SCAN_START_ANGLE   = 3'd6,
    REG_ANGLE_STEP         = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    CAUSE_KEPT    = 2'd0,
    CAUSE_SECTOR  = 2'd1,
    CAUSE_OUTLIER = 2'd2
  } cause_e;

  typedef struct packed {
    logic [RANGE_BITS-1:0]     range_mm;
    logic [INTENSITY_BITS-1:0] intensity;
    logic                      end_of_scan;
  } in_item_t;

  typedef struct packed {
    logic [RANGE_BITS-1:0]     filtered_range_mm;
    logic [INTENSITY_BITS-1:0] filtered_intensity;
    logic [1:0]                removal_cause;
    logic                      scan_done;
  } out_item_t;

  typedef struct packed {
    logic [RANGE_BITS-1:0]        isolation_limit;
    logic                         sector_mask_enable;
    logic signed [ANGLE_BITS-1:0] sector_low_angle;
    logic signed [ANGLE_BITS-1:0] sector_high_angle;
    logic [RANGE_BITS-1:0]        valid_range_low;
    logic [RANGE_BITS-1:0]        valid_range_high;
    logic signed [ANGLE_BITS-1:0] scan_start_angle;
    logic signed [ANGLE_BITS-1:0] angle_step;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    isolation_limit:    RANGE_BITS'(100),
    sector_mask_enable: 1'b0,
    sector_low_angle:   '0,
    sector_high_angle:  '0,
    valid_range_low:    '0,
    valid_range_high:   RANGE_BITS'(65534),
    scan_start_angle:   {1'b1, {(ANGLE_BITS-1){1'b0}}},
    angle_step:         ANGLE_BITS'(64)
  };

  typedef struct packed {
    logic [RANGE_BITS-1:0]     range_mm;
    logic [INTENSITY_BITS-1:0] intensity;
    logic                      end_of_scan;
    logic                      masked;
    logic [1:0]                sample_count;
  } cmd_t;

endpackage

>>> src/lssof_front.sv
module lssof_front
  import lssof_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     push_i,
  input  logic     full_i,
  input  in_item_t item_i,
  output logic     cmd_push_o,
  output cmd_t     cmd_o
);

  logic [1:0]            count_q, count_d;
  logic [ANGLE_BITS-1:0] angle_q, angle_d;
  logic [ANGLE_BITS-1:0] angle;
  logic                  in_sector;
  logic                  accept;

  assign accept = push_i && !full_i;
  assign angle  = (count_q == 2'd0) ? cfg_i.scan_start_angle : angle_q;

  assign in_sector = cfg_i.sector_mask_enable
                     && ($signed(angle) >= cfg_i.sector_low_angle)
                     && ($signed(angle) <= cfg_i.sector_high_angle);

  always_comb begin
    count_d = count_q;
    angle_d = angle_q;
    if (accept) begin
      angle_d = angle + cfg_i.angle_step;
      if (item_i.end_of_scan) begin
        count_d = 2'd0;
      end else if (count_q != 2'd3) begin
        count_d = count_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
      angle_q <= CFG_RESET.scan_start_angle;
    end else begin
      count_q <= count_d;
      angle_q <= angle_d;
    end
  end

  assign cmd_push_o         = accept;
  assign cmd_o.range_mm     = item_i.range_mm;
  assign cmd_o.intensity    = item_i.intensity;
  assign cmd_o.end_of_scan  = item_i.end_of_scan;
  assign cmd_o.masked       = in_sector;
  assign cmd_o.sample_count = count_q;

endmodule

>>> src/lssof_cmd_fifo.sv
module lssof_cmd_fifo
  import lssof_pkg::*;
#(
  parameter int unsigned Depth = CMD_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> src/lssof_back.sv
module lssof_back
  import lssof_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      cmd_empty_i,
  input  cmd_t      cmd_i,
  output logic      cmd_pop_o,
  input  logic      pop_i,
  output logic      empty_o,
  output out_item_t item_o
);

  typedef enum logic [1:0] {
    KIND_RAW,
    KIND_EDGE,
    KIND_INTERIOR
  } kind_e;

  typedef enum logic [1:0] {
    SRC_P0,
    SRC_P1,
    SRC_NEW
  } src_e;

  localparam logic [RANGE_BITS-1:0] RangeInf = '1;

  logic [RANGE_BITS-1:0]     p_range_q [2];
  logic [INTENSITY_BITS-1:0] p_int_q   [2];
  logic                      p_mask_q  [2];
  logic [RANGE_BITS-1:0]     last_q, last_d;
  logic [1:0]                k_q, k_d;
  logic                      out_valid_q, out_valid_d;
  out_item_t                 out_q;

  kind_e                     kind;
  src_e                      src;
  logic                      done;
  logic [1:0]                n_res;
  logic [RANGE_BITS-1:0]     c_range, right_range, diff_prev, diff_next;
  logic [INTENSITY_BITS-1:0] c_int;
  logic                      c_mask, outlier, last_k, step, emit, out_ready;
  out_item_t                 res;

  function automatic logic range_ok(input logic [RANGE_BITS-1:0] r, input cfg_t cfg);
    range_ok = (r != RangeInf) && (r >= cfg.valid_range_low) && (r <= cfg.valid_range_high);
  endfunction

  always_comb begin
    kind  = KIND_RAW;
    src   = SRC_NEW;
    done  = 1'b0;
    n_res = 2'd0;
    unique case (cmd_i.sample_count)
      2'd0: begin
        n_res = {1'b0, cmd_i.end_of_scan};
        done  = 1'b1;
      end
      2'd1: begin
        n_res = cmd_i.end_of_scan ? 2'd2 : 2'd0;
        if (k_q == 2'd0) begin
          src = SRC_P0;
        end else begin
          done = 1'b1;
        end
      end
      2'd2: begin
        n_res = cmd_i.end_of_scan ? 2'd3 : 2'd2;
        if (k_q == 2'd0) begin
          kind = KIND_EDGE;
          src  = SRC_P0;
        end else if (k_q == 2'd1) begin
          kind = KIND_INTERIOR;
          src  = SRC_P1;
        end else begin
          kind = KIND_EDGE;
          done = 1'b1;
        end
      end
      2'd3: begin
        n_res = cmd_i.end_of_scan ? 2'd2 : 2'd1;
        if (k_q == 2'd0) begin
          kind = KIND_INTERIOR;
          src  = SRC_P0;
        end else begin
          kind = KIND_EDGE;
          done = 1'b1;
        end
      end
    endcase
  end

  always_comb begin
    unique case (src)
      SRC_P0: begin
        c_range = p_range_q[0];
        c_int   = p_int_q[0];
        c_mask  = p_mask_q[0];
      end
      SRC_P1: begin
        c_range = p_range_q[1];
        c_int   = p_int_q[1];
        c_mask  = p_mask_q[1];
      end
      default: begin
        c_range = cmd_i.range_mm;
        c_int   = cmd_i.intensity;
        c_mask  = cmd_i.masked;
      end
    endcase
  end

  assign right_range = cmd_i.masked ? RangeInf : cmd_i.range_mm;
  assign diff_prev   = (c_range > last_q) ? c_range - last_q : last_q - c_range;
  assign diff_next   = (c_range > right_range) ? c_range - right_range : right_range - c_range;
  assign outlier     = range_ok(c_range, cfg_i) && range_ok(last_q, cfg_i)
                       && range_ok(right_range, cfg_i)
                       && (diff_prev > cfg_i.isolation_limit)
                       && (diff_next > cfg_i.isolation_limit);

  always_comb begin
    res.filtered_range_mm  = c_range;
    res.filtered_intensity = c_int;
    res.removal_cause      = CAUSE_KEPT;
    res.scan_done          = done;
    if (kind != KIND_RAW && c_mask) begin
      res.filtered_range_mm  = RangeInf;
      res.filtered_intensity = '0;
      res.removal_cause      = CAUSE_SECTOR;
    end else if (kind == KIND_INTERIOR && outlier) begin
      res.filtered_range_mm  = RangeInf;
      res.filtered_intensity = '0;
      res.removal_cause      = CAUSE_OUTLIER;
    end
  end

  assign out_ready   = !out_valid_q || pop_i;
  assign last_k      = (n_res == 2'd0) || (k_q == n_res - 2'd1);
  assign step        = !cmd_empty_i && ((n_res == 2'd0) || out_ready);
  assign emit        = step && (n_res != 2'd0);
  assign cmd_pop_o   = step && last_k;
  assign k_d         = step ? (last_k ? 2'd0 : k_q + 2'd1) : k_q;
  assign out_valid_d = emit || (out_valid_q && !pop_i);

  always_comb begin
    last_d = last_q;
    if (emit && kind != KIND_RAW) begin
      last_d = res.filtered_range_mm;
    end
    if (cmd_pop_o && cmd_i.end_of_scan) begin
      last_d = RangeInf;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q      <= RangeInf;
      k_q         <= 2'd0;
      out_valid_q <= 1'b0;
      p_range_q   <= '{RangeInf, RangeInf};
      p_int_q     <= '{'0, '0};
      p_mask_q    <= '{1'b0, 1'b0};
    end else begin
      last_q      <= last_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
      if (cmd_pop_o) begin
        if (cmd_i.sample_count == 2'd1) begin
          p_range_q[1] <= cmd_i.range_mm;
          p_int_q[1]   <= cmd_i.intensity;
          p_mask_q[1]  <= cmd_i.masked;
        end else begin
          p_range_q[0] <= cmd_i.range_mm;
          p_int_q[0]   <= cmd_i.intensity;
          p_mask_q[0]  <= cmd_i.masked;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= res;
    end
  end

  assign empty_o = !out_valid_q;
  assign item_o  = out_q;

endmodule

>>> src/lidar_scan_sector_and_outlier_filter.sv
// Channel   Direction  Handshake                   Payload
// input     in         push / full                 in_item_i (range, intensity, end mark)
// result    out        empty / pop                 out_item_o (range, intensity, cause, done)
// config    in         cfg_valid_i / cfg_ready_o   cfg_index_i, cfg_data_i
//
// One sample is accepted per cycle while the queue is not full; a released result passes
// through the command queue and the result register before it can be popped. The result
// stage pops a transaction with its last result; the end-of-scan sample of a scan of two
// or more samples yields two or three, absorbed by the queue between front and back parts.
// Reset is asynchronous and restores every control and configuration register.
// A stalled result holds the back part, which fills the queue and then raises full.
`include "lidar_scan_sector_and_outlier_filter_defines.svh"

module lidar_scan_sector_and_outlier_filter
  import lssof_pkg::*;
#(
  parameter int unsigned CmdDepth = CMD_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  in_item_t   in_item_i,
  output logic       empty,
  input  logic       pop,
  output out_item_t  out_item_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [2:0] cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  cfg_t cfg_q;
  logic cmd_push, cmd_pop, cmd_full, cmd_empty;
  cmd_t cmd_in, cmd_head;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_ISOLATION_LIMIT:    cfg_q.isolation_limit    <= cfg_data_i[RANGE_BITS-1:0];
        REG_SECTOR_MASK_ENABLE: cfg_q.sector_mask_enable <= cfg_data_i[0];
        REG_SECTOR_LOW_ANGLE:   cfg_q.sector_low_angle   <= cfg_data_i[ANGLE_BITS-1:0];
        REG_SECTOR_HIGH_ANGLE:  cfg_q.sector_high_angle  <= cfg_data_i[ANGLE_BITS-1:0];
        REG_VALID_RANGE_LOW:    cfg_q.valid_range_low    <= cfg_data_i[RANGE_BITS-1:0];
        REG_VALID_RANGE_HIGH:   cfg_q.valid_range_high   <= cfg_data_i[RANGE_BITS-1:0];
        REG_SCAN_START_ANGLE:   cfg_q.scan_start_angle   <= cfg_data_i[ANGLE_BITS-1:0];
        REG_ANGLE_STEP:         cfg_q.angle_step         <= cfg_data_i[ANGLE_BITS-1:0];
      endcase
    end
  end

  lssof_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .push_i     (push),
    .full_i     (cmd_full),
    .item_i     (in_item_i),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  lssof_cmd_fifo #(
    .Depth (CmdDepth)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .empty_o (cmd_empty),
    .data_o  (cmd_head)
  );

  lssof_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_head),
    .cmd_pop_o   (cmd_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .item_o      (out_item_o)
  );

  assign full = cmd_full;

  `LSSOF_ASSERT_IMPLIES(a_removed_is_blank, clk_i, rst_ni,
    !empty && (out_item_o.removal_cause != CAUSE_KEPT),
    (out_item_o.filtered_range_mm == '1) && (out_item_o.filtered_intensity == '0))
  `LSSOF_ASSERT_IMPLIES(a_scan_end_not_outlier, clk_i, rst_ni,
    !empty && out_item_o.scan_done,
    out_item_o.removal_cause != CAUSE_OUTLIER)
  `LSSOF_ASSERT_NEXT(a_held_result_stays, clk_i, rst_ni,
    !empty && !pop && !cmd_empty,
    !empty)

endmodule
